// ----- rtl/cdda_pkg.sv -----
`timescale 1ns / 1ps
package cdda_pkg;

   // Normalization row: one month step per cell
   localparam int NUM_CELLS   = 40;
   localparam int PREP_STAGES = 3;
   localparam int LATENCY     = PREP_STAGES + NUM_CELLS;

   localparam logic [9:0] MAX_DUR_DAYS = 10'd1023;

   // year / 400 by reciprocal: floor(year * 5243 / 2^21), exact below 2^15
   localparam int          RECIP_SHIFT  = 21;
   localparam logic [12:0] YEAR_RECIP   = 13'd5243;
   localparam logic [14:0] LEAP_CYCLE   = 15'd400;
   localparam logic [8:0]  LEAP_LAST    = 9'd399;
   localparam logic [8:0]  CENTURY_1    = 9'd100;
   localparam logic [8:0]  CENTURY_2    = 9'd200;
   localparam logic [8:0]  CENTURY_3    = 9'd300;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;
   localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

   localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
   localparam logic [6:0] HOURS_PER_DAY    = 7'd24;

   localparam logic [4:0] DAYS_LONG  = 5'd31;
   localparam logic [4:0] DAYS_SHORT = 5'd30;
   localparam logic [4:0] DAYS_LEAP  = 5'd29;
   localparam logic [4:0] DAYS_FEB   = 5'd28;

   typedef struct packed {
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [10:0] day;
      logic [3:0]  month;
      logic [14:0] year;
      logic [8:0]  year_mod400;
   } cdda_item_type;

   function automatic logic is_leap(input logic [8:0] year_mod400);
      is_leap = (year_mod400[1:0] == 2'd0) && (year_mod400 != CENTURY_1) &&
                (year_mod400 != CENTURY_2) && (year_mod400 != CENTURY_3);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      len = DAYS_LONG;
      unique case (month)
         MONTH_FEB: len = leap ? DAYS_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
         default: len = DAYS_LONG;
      endcase
      month_len = len;
   endfunction

endpackage

// ----- rtl/calendar_date_duration_adder.sv -----
`timescale 1ns / 1ps
// Adds a duration (minutes, hours, days, months, years) to a start date and time.
// A transaction is taken whenever start is high; busy stays low, so one transaction
// can enter every cycle. Each result is marked by rsp_strobe for one cycle,
// and must be captured then since the receiver cannot stall it. The pipeline
// is three setup stages (carry chain, year mod 400 by reciprocal multiply,
// remainder) plus a row of 40 cells, each of which subtracts at most one month
// length from the day total.
module calendar_date_duration_adder import cdda_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [5:0]    req_start_minute,
   input  logic [4:0]    req_start_hour,
   input  logic [4:0]    req_start_day,
   input  logic [3:0]    req_start_month,
   input  logic [13:0]   req_start_year,
   input  logic [5:0]    req_dur_minutes,
   input  logic [4:0]    req_dur_hours,
   input  logic [9:0]    req_dur_days,
   input  logic [3:0]    req_dur_months,
   input  logic [6:0]    req_dur_years,
   output logic          rsp_strobe,
   output logic [5:0]    rsp_end_minute,
   output logic [4:0]    rsp_end_hour,
   output logic [4:0]    rsp_end_day,
   output logic [3:0]    rsp_end_month,
   output logic [13:0]   rsp_end_year
);

   logic          chain_valid [NUM_CELLS+1];
   cdda_item_type chain_item  [NUM_CELLS+1];

   assign busy = 1'b0;

   cdda_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start),
      .start_minute (req_start_minute),
      .start_hour   (req_start_hour),
      .start_day    (req_start_day),
      .start_month  (req_start_month),
      .start_year   (req_start_year),
      .dur_minutes  (req_dur_minutes),
      .dur_hours    (req_dur_hours),
      .dur_days     (req_dur_days),
      .dur_months   (req_dur_months),
      .dur_years    (req_dur_years),
      .out_valid    (chain_valid[0]),
      .out_item     (chain_item[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      cdda_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_item  (chain_item[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_item  (chain_item[i+1])
      );
   end

   assign rsp_strobe     = chain_valid[NUM_CELLS];
   assign rsp_end_minute = chain_item[NUM_CELLS].minute;
   assign rsp_end_hour   = chain_item[NUM_CELLS].hour;
   assign rsp_end_day    = chain_item[NUM_CELLS].day[4:0];
   assign rsp_end_month  = chain_item[NUM_CELLS].month;
   assign rsp_end_year   = chain_item[NUM_CELLS].year[13:0];

endmodule

// ----- rtl/cdda_prep.sv -----
`timescale 1ns / 1ps
module cdda_prep import cdda_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [5:0]    start_minute,
   input  logic [4:0]    start_hour,
   input  logic [4:0]    start_day,
   input  logic [3:0]    start_month,
   input  logic [13:0]   start_year,
   input  logic [5:0]    dur_minutes,
   input  logic [4:0]    dur_hours,
   input  logic [9:0]    dur_days,
   input  logic [3:0]    dur_months,
   input  logic [6:0]    dur_years,
   output logic          out_valid,
   output cdda_item_type out_item
);

   logic [9:0]    days_sat;
   logic [6:0]    msum;
   logic [6:0]    hsum;
   logic [6:0]    mrem;
   logic [6:0]    hrem;
   logic [1:0]    mcarry;
   logic [1:0]    hcarry;
   logic [10:0]   day_sum;
   logic [4:0]    mon_sum;
   logic [4:0]    mon_wrap;
   logic [1:0]    ycarry;
   cdda_item_type a_in;

   logic          a_valid_ff;
   cdda_item_type a_item_ff;
   logic          b_valid_ff;
   cdda_item_type b_item_ff;
   logic [6:0]    b_quot_ff;
   logic          c_valid_ff;
   cdda_item_type c_item_ff;
   cdda_item_type c_in;

   logic [27:0]   prod;
   logic [14:0]   cycles_years;
   logic [14:0]   year_rem;

   // Stage A: carry chain and month wrap
   always_comb begin
      days_sat = (dur_days > MAX_DUR_DAYS) ? MAX_DUR_DAYS : dur_days;
      msum = 7'(start_minute) + 7'(dur_minutes);
      if (msum >= 7'(2 * MINUTES_PER_HOUR)) begin
         mrem = msum - 7'(2 * MINUTES_PER_HOUR);
         mcarry = 2'd2;
      end else if (msum >= MINUTES_PER_HOUR) begin
         mrem = msum - MINUTES_PER_HOUR;
         mcarry = 2'd1;
      end else begin
         mrem = msum;
         mcarry = 2'd0;
      end
      hsum = 7'(start_hour) + 7'(dur_hours) + 7'(mcarry);
      if (hsum >= 7'(2 * HOURS_PER_DAY)) begin
         hrem = hsum - 7'(2 * HOURS_PER_DAY);
         hcarry = 2'd2;
      end else if (hsum >= HOURS_PER_DAY) begin
         hrem = hsum - HOURS_PER_DAY;
         hcarry = 2'd1;
      end else begin
         hrem = hsum;
         hcarry = 2'd0;
      end
      day_sum = 11'(start_day) + 11'(days_sat) + 11'(hcarry);
      mon_sum = 5'(start_month) + 5'(dur_months);
      if (mon_sum > 5'(2 * MONTHS_PER_YEAR)) begin
         mon_wrap = mon_sum - 5'(2 * MONTHS_PER_YEAR);
         ycarry = 2'd2;
      end else if (mon_sum > 5'(MONTHS_PER_YEAR)) begin
         mon_wrap = mon_sum - 5'(MONTHS_PER_YEAR);
         ycarry = 2'd1;
      end else begin
         mon_wrap = mon_sum;
         ycarry = 2'd0;
      end
      a_in.minute = mrem[5:0];
      a_in.hour = hrem[4:0];
      a_in.day = (day_sum == 11'd0) ? 11'd1 : day_sum;
      a_in.month = (mon_wrap == 5'd0) ? MONTH_JAN : mon_wrap[3:0];
      a_in.year = 15'(start_year) + 15'(dur_years) + 15'(ycarry);
      a_in.year_mod400 = 9'd0;
   end

   assign prod = 28'(a_item_ff.year) * 28'(YEAR_RECIP);
   assign cycles_years = 15'(b_quot_ff) * LEAP_CYCLE;
   assign year_rem = b_item_ff.year - cycles_years;

   always_comb begin
      c_in = b_item_ff;
      c_in.year_mod400 = year_rem[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // Stage B registers the quotient, stage C the remainder year mod 400
   always_ff @(posedge clock) begin
      a_item_ff <= a_in;
      b_item_ff <= a_item_ff;
      b_quot_ff <= prod[RECIP_SHIFT +: 7];
      c_item_ff <= c_in;
   end

   assign out_valid = c_valid_ff;
   assign out_item  = c_item_ff;

endmodule

// ----- rtl/cdda_cell.sv -----
`timescale 1ns / 1ps
module cdda_cell import cdda_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   input  cdda_item_type up_item,
   output logic          dn_valid,
   output cdda_item_type dn_item
);

   logic          valid_ff;
   cdda_item_type item_ff;
   cdda_item_type item_in;
   logic [4:0]    len;

   assign len = month_len(up_item.month, is_leap(up_item.year_mod400));

   // Peel one month off the day total when it does not fit
   always_comb begin
      item_in = up_item;
      if (up_item.day > 11'(len)) begin
         item_in.day = up_item.day - 11'(len);
         if (up_item.month >= MONTH_DEC) begin
            item_in.month = MONTH_JAN;
            item_in.year = up_item.year + 15'd1;
            item_in.year_mod400 = (up_item.year_mod400 == LEAP_LAST) ? 9'd0 :
                                  up_item.year_mod400 + 9'd1;
         end else begin
            item_in.month = up_item.month + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

// ----- rtl/cdda_checker.sv -----
`timescale 1ns / 1ps
module cdda_checker import cdda_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [5:0]  rsp_end_minute,
   input logic [4:0]  rsp_end_hour,
   input logic [4:0]  rsp_end_day,
   input logic [3:0]  rsp_end_month
);

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("transaction produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a transaction");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_end_minute < 6'd60) && (rsp_end_hour < 5'd24))
      else $error("end time out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_end_day != 5'd0) && (rsp_end_month != 4'd0) &&
                     (rsp_end_month <= MONTH_DEC))
      else $error("end date out of range");

endmodule

bind calendar_date_duration_adder cdda_checker u_cdda_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_end_minute (rsp_end_minute),
   .rsp_end_hour   (rsp_end_hour),
   .rsp_end_day    (rsp_end_day),
   .rsp_end_month  (rsp_end_month)
);

// ----- tb/sv/calendar_date_duration_adder_tb.sv -----
`timescale 1ns / 1ps
module calendar_date_duration_adder_tb;
   import cdda_pkg::*;

   localparam int RANDOM_ITEMS   = 1927;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [5:0]  start_minute;
      logic [4:0]  start_hour;
      logic [4:0]  start_day;
      logic [3:0]  start_month;
      logic [13:0] start_year;
      logic [5:0]  dur_minutes;
      logic [4:0]  dur_hours;
      logic [9:0]  dur_days;
      logic [3:0]  dur_months;
      logic [6:0]  dur_years;
   } duration_req_type;

   typedef struct packed {
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } end_stamp_type;

   typedef struct {
      duration_req_type fields;
      bit               drain_first;
   } queued_req_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   duration_req_type req_drv = '0;
   logic             rsp_strobe;
   logic [5:0]       rsp_end_minute;
   logic [4:0]       rsp_end_hour;
   logic [4:0]       rsp_end_day;
   logic [3:0]       rsp_end_month;
   logic [13:0]      rsp_end_year;

   queued_req_type   pending_reqs[$];
   end_stamp_type    expected_ends[$];
   logic             req_taken = 1'b0;
   int               burst_left = 0;
   int               gap_left = 0;
   int               idle_cycles = 0;
   int               errors = 0;

   calendar_date_duration_adder dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_start_minute (req_drv.start_minute),
      .req_start_hour   (req_drv.start_hour),
      .req_start_day    (req_drv.start_day),
      .req_start_month  (req_drv.start_month),
      .req_start_year   (req_drv.start_year),
      .req_dur_minutes  (req_drv.dur_minutes),
      .req_dur_hours    (req_drv.dur_hours),
      .req_dur_days     (req_drv.dur_days),
      .req_dur_months   (req_drv.dur_months),
      .req_dur_years    (req_drv.dur_years),
      .rsp_strobe       (rsp_strobe),
      .rsp_end_minute   (rsp_end_minute),
      .rsp_end_hour     (rsp_end_hour),
      .rsp_end_day      (rsp_end_day),
      .rsp_end_month    (rsp_end_month),
      .rsp_end_year     (rsp_end_year)
   );

   always #5 clock = ~clock;

   function automatic int unsigned days_in_month(input int unsigned month,
                                                 input int unsigned year);
      bit leap;
      leap = (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
      if (month == 32'(MONTH_FEB))
         return 32'(leap ? DAYS_LEAP : DAYS_FEB);
      if (month == 32'(MONTH_APR) || month == 32'(MONTH_JUN) ||
          month == 32'(MONTH_SEP) || month == 32'(MONTH_NOV))
         return 32'(DAYS_SHORT);
      return 32'(DAYS_LONG);
   endfunction

   function automatic end_stamp_type add_duration(input duration_req_type r);
      int unsigned   ddays, msum, hsum, day, month, year, len;
      end_stamp_type e;
      ddays = 32'(r.dur_days);
      if (ddays > 32'(MAX_DUR_DAYS))
         ddays = 32'(MAX_DUR_DAYS);
      msum = 32'(r.start_minute) + 32'(r.dur_minutes);
      hsum = 32'(r.start_hour) + 32'(r.dur_hours) + msum / 32'(MINUTES_PER_HOUR);
      day = 32'(r.start_day) + ddays + hsum / 32'(HOURS_PER_DAY);
      if (day == 0)
         day = 1;
      month = 32'(r.start_month) + 32'(r.dur_months);
      year = 32'(r.start_year) + 32'(r.dur_years);
      if (month == 0)
         month = 32'(MONTH_JAN);
      while (month > 32'(MONTHS_PER_YEAR)) begin
         month -= 32'(MONTHS_PER_YEAR);
         year++;
      end
      // peel off one month length at a time
      len = days_in_month(month, year);
      while (day > len) begin
         day -= len;
         month++;
         if (month > 32'(MONTHS_PER_YEAR)) begin
            month = 32'(MONTH_JAN);
            year++;
         end
         len = days_in_month(month, year);
      end
      e.minute = 6'(msum % 32'(MINUTES_PER_HOUR));
      e.hour = 5'(hsum % 32'(HOURS_PER_DAY));
      e.day = 5'(day);
      e.month = 4'(month);
      e.year = 14'(year);
      return e;
   endfunction

   function automatic int field_miss(input string name, input int unsigned want,
                                     input int unsigned got);
      if (want == got)
         return 0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
   endfunction

   task automatic queue_req(input int smin, input int shr, input int sday, input int smon,
                            input int syr, input int dmin, input int dhr, input int dday,
                            input int dmon, input int dyr);
      queued_req_type q;
      q.fields.start_minute = 6'(smin);
      q.fields.start_hour = 5'(shr);
      q.fields.start_day = 5'(sday);
      q.fields.start_month = 4'(smon);
      q.fields.start_year = 14'(syr);
      q.fields.dur_minutes = 6'(dmin);
      q.fields.dur_hours = 5'(dhr);
      q.fields.dur_days = 10'(dday);
      q.fields.dur_months = 4'(dmon);
      q.fields.dur_years = 7'(dyr);
      q.drain_first = 1'b0;
      pending_reqs.push_back(q);
   endtask

   function automatic duration_req_type random_req();
      duration_req_type r;
      bit               wild;
      wild = ($urandom_range(0, 3) == 0);
      r.start_minute = wild ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
      r.start_hour = wild ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
      r.start_day = wild ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 31));
      r.start_month = wild ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
      if (wild)
         r.start_year = 14'($urandom_range(0, 16383));
      else if ($urandom_range(0, 2) == 0)
         r.start_year = 14'(100 * $urandom_range(0, 99) + $urandom_range(0, 4));
      else
         r.start_year = 14'($urandom_range(0, 9999));
      r.dur_minutes = wild ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
      r.dur_hours = wild ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
      r.dur_days = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 62)) :
                   10'($urandom_range(0, 1023));
      r.dur_months = wild ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 11));
      r.dur_years = wild ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 99));
      return r;
   endfunction

   // Driver: hold a transaction until taken, then advance through bursts and gaps
   always @(negedge clock) begin
      if (reset || (start && !req_taken)) begin
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain_first && expected_ends.size() != 0)) begin
         start <= 1'b0;
      end else begin
         req_drv <= pending_reqs[0].fields;
         start <= 1'b1;
         pending_reqs.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // Monitor: check results against the oldest prediction, record new transactions
   always @(posedge clock) begin : monitor
      end_stamp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (expected_ends.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %0d:%0d %0d/%0d/%0d",
                        $time, rsp_end_hour, rsp_end_minute, rsp_end_day, rsp_end_month,
                        rsp_end_year);
            end else begin
               want = expected_ends.pop_front();
               errors += field_miss("end_minute", 32'(want.minute), 32'(rsp_end_minute));
               errors += field_miss("end_hour", 32'(want.hour), 32'(rsp_end_hour));
               errors += field_miss("end_day", 32'(want.day), 32'(rsp_end_day));
               errors += field_miss("end_month", 32'(want.month), 32'(rsp_end_month));
               errors += field_miss("end_year", 32'(want.year), 32'(rsp_end_year));
            end
         end
         if (start && !busy)
            expected_ends.push_back(add_duration(req_drv));
         req_taken <= start && !busy;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      queued_req_type q;
      // zero everywhere, then every field at its all-ones value
      queue_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      queue_req(63, 31, 31, 15, 16383, 63, 31, 1023, 15, 127);
      // carries through minute, hour, day, month and year
      queue_req(59, 23, 31, 12, 9999, 59, 23, 0, 0, 0);
      queue_req(63, 31, 10, 3, 2020, 63, 31, 0, 0, 0);
      // leap rule around February
      queue_req(0, 0, 28, 2, 2000, 0, 0, 1, 0, 0);
      queue_req(0, 0, 28, 2, 1900, 0, 0, 1, 0, 0);
      queue_req(0, 0, 28, 2, 2024, 0, 0, 1, 0, 0);
      queue_req(0, 0, 28, 2, 2100, 0, 0, 1, 0, 0);
      queue_req(12, 6, 29, 2, 2400, 0, 0, 365, 0, 0);
      queue_req(0, 0, 29, 2, 1600, 0, 0, 0, 0, 1);
      // start day past the end of its month
      queue_req(0, 0, 31, 4, 2023, 0, 0, 0, 0, 0);
      queue_req(0, 0, 31, 2, 2023, 0, 0, 0, 0, 0);
      // month total past twelve
      queue_req(0, 0, 15, 12, 2000, 0, 0, 0, 11, 0);
      queue_req(0, 0, 15, 15, 2000, 0, 0, 0, 15, 0);
      // day total zero, with and without an hour carry
      queue_req(0, 0, 0, 5, 2001, 0, 0, 0, 0, 0);
      queue_req(0, 23, 0, 5, 2001, 0, 1, 0, 0, 0);
      // start month zero, alone and with a month duration
      queue_req(0, 0, 1, 0, 2010, 0, 0, 0, 0, 0);
      queue_req(0, 0, 1, 0, 2010, 0, 0, 0, 7, 0);
      // longest durations and year wrap
      queue_req(0, 0, 31, 12, 1999, 0, 0, 1023, 0, 0);
      queue_req(59, 23, 31, 1, 9999, 59, 23, 1023, 11, 99);
      queue_req(0, 0, 1, 1, 16383, 0, 0, 0, 0, 127);
      queue_req(30, 12, 31, 12, 16383, 0, 0, 1, 0, 0);
      queue_req(30, 12, 15, 6, 2021, 45, 13, 100, 6, 3);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         q.fields = random_req();
         q.drain_first = (i == 0) || ($urandom_range(0, 149) == 0);
         pending_reqs.push_back(q);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || start || expected_ends.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
